// File: hw/rtl/ymr_pkg.sv
`default_nettype none
package ymr_pkg;

  localparam int PAYLOAD_BYTES = 128;
  localparam int FRAME_BYTES = PAYLOAD_BYTES + 5;
  localparam int BUFFER_BYTES = 4096;
  localparam int OFFSET_BITS = $clog2(PAYLOAD_BYTES);

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;
  localparam logic [7:0] C_BYTE = 8'h43;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [24:0] SIZE_LIMIT_RESET = 25'd131072;
  localparam logic [23:0] ERASE1_ADDR = 24'h010000;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_END = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_EOT2 = 2'd2;
  localparam logic [1:0] PH_END = 2'd3;

  localparam logic [2:0] KIND_REPLY = 3'd0;
  localparam logic [2:0] KIND_ERASE = 3'd1;
  localparam logic [2:0] KIND_FLUSH = 3'd2;
  localparam logic [2:0] KIND_DONE = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;
  localparam logic [2:0] KIND_READ = 3'd5;

  localparam logic ERR_CRC = 1'b0;
  localparam logic ERR_SIZE = 1'b1;

  // one beat of a reply sequence
  localparam logic [3:0] BT_ERASE0 = 4'd0;
  localparam logic [3:0] BT_ERASE1 = 4'd1;
  localparam logic [3:0] BT_ACK = 4'd2;
  localparam logic [3:0] BT_C = 4'd3;
  localparam logic [3:0] BT_NAK = 4'd4;
  localparam logic [3:0] BT_DONE = 4'd5;
  localparam logic [3:0] BT_FLUSH = 4'd6;
  localparam logic [3:0] BT_ERRCRC = 4'd7;
  localparam logic [3:0] BT_ERRSIZE = 4'd8;
  localparam logic [3:0] BT_READ = 4'd9;

  typedef struct packed {
    logic [2:0] count;
    logic [3:0][3:0] beats;
    logic [23:0] flush_addr;
    logic [31:0] size;
    logic zero_read;
  } desc_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ymodem_crc_receiver.sv
`default_nettype none
// ymodem receiver, 128-byte packets checked with crc-16/xmodem
// input channel (in_valid/in_ready): command, data_byte, read_address; one beat
// per received byte, one per frame end, one per staging buffer read
// output channel (out_valid/out_ready): kind, value_byte, flash_address,
// transfer_size, error_code, last; an input beat yields zero to four output beats,
// last marks the final one
// throughput: one input beat per cycle while in_ready is high; an input beat with n
// results holds the output channel for n beats, set by the single output port
// size_limit is written through cfg_we/cfg_wdata; write it only while idle (not enforced)
// reset: a clearing pass zeroes the staging buffer, one entry per cycle, and
// in_ready stays low until all BUFFER_BYTES entries (4096 by default) are cleared
// a stalled output keeps the current beat; one more input beat is held in the
// first stage, after which in_ready drops
module ymodem_crc_receiver #(
  parameter int BUFFER_BYTES = ymr_pkg::BUFFER_BYTES
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [24:0] cfg_wdata,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] command,
  input wire logic [7:0] data_byte,
  input wire logic [11:0] read_address,
  output logic out_valid,
  input wire logic out_ready,
  output logic [2:0] kind,
  output logic [7:0] value_byte,
  output logic [23:0] flash_address,
  output logic [31:0] transfer_size,
  output logic error_code,
  output logic last
);

  localparam int ABITS = $clog2(BUFFER_BYTES);

  logic busy, in_free, accept, desc_valid;
  ymr_pkg::desc_t desc;
  logic ram_we, ram_re;
  logic [ABITS-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;

  assign in_ready = !busy && in_free;
  assign accept = in_valid && in_ready;

  ymr_core #(.BUFFER_BYTES(BUFFER_BYTES)) u_core (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .accept(accept), .command(command), .data_byte(data_byte),
    .read_address(read_address), .busy(busy), .desc_valid(desc_valid), .desc(desc),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
    .ram_re(ram_re), .ram_raddr(ram_raddr)
  );

  ymr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  ymr_out u_out (
    .clk(clk), .rst(rst), .desc_valid(desc_valid), .desc(desc), .rdata(ram_rdata),
    .in_free(in_free), .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .value_byte(value_byte), .flash_address(flash_address),
    .transfer_size(transfer_size), .error_code(error_code), .last(last)
  );

endmodule
`default_nettype wire

// File: hw/rtl/ymr_ram.sv
`default_nettype none
module ymr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic re,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/ymr_core.sv
`default_nettype none
module ymr_core #(
  parameter int BUFFER_BYTES = ymr_pkg::BUFFER_BYTES
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [24:0] cfg_wdata,
  input wire logic accept,
  input wire logic [1:0] command,
  input wire logic [7:0] data_byte,
  input wire logic [11:0] read_address,
  output logic busy,
  output logic desc_valid,
  output ymr_pkg::desc_t desc,
  output logic ram_we,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr,
  output logic [7:0] ram_wdata,
  output logic ram_re,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_raddr
);

  localparam int ABITS = $clog2(BUFFER_BYTES);
  localparam int SLOTS = BUFFER_BYTES / ymr_pkg::PAYLOAD_BYTES;
  localparam int SW = $clog2(SLOTS);
  localparam int OB = ymr_pkg::OFFSET_BITS;

  logic [ABITS:0] clr_cnt;
  logic [24:0] size_limit;
  logic [1:0] phase, phase_next;
  logic halted, halted_next;
  logic [7:0] expected_block, expected_block_next;
  logic [SW-1:0] slot_count, slot_count_next;
  logic [7:0] flush_block_index, flush_block_index_next;
  logic [7:0] byte_position, byte_position_next;
  logic [7:0] frame_type, frame_type_next;
  logic [7:0] block_number, block_number_next;
  logic [7:0] block_complement, block_complement_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic zero_seen, zero_seen_next;
  logic [2:0] size_bytes_taken, size_bytes_taken_next;
  logic [31:0] pending_size, pending_size_next;
  logic [31:0] size_held, size_held_next;

  logic hdr_data, null_block, pay_write;
  logic [7:0] off;
  logic [31:0] size_shifted, ra_wide;
  logic [23:0] flush_addr;
  logic [SW:0] slot_inc;

  assign busy = !clr_cnt[ABITS];
  assign hdr_data = phase == ymr_pkg::PH_DATA && frame_type == ymr_pkg::SOH_BYTE &&
                    block_number == expected_block && block_complement == ~block_number;
  assign null_block = block_number == 8'h00 && block_complement == 8'hFF;
  assign off = byte_position - 8'd3;
  assign flush_addr = 24'({flush_block_index, {ABITS{1'b0}}});
  assign slot_inc = {1'b0, slot_count} + 1'b1;
  assign ra_wide = 32'(read_address);

  always_comb begin
    case (size_bytes_taken)
      3'd1: size_shifted = {pending_size[7:0], 24'h0};
      3'd2: size_shifted = {pending_size[15:0], 16'h0};
      3'd3: size_shifted = {pending_size[23:0], 8'h0};
      3'd4: size_shifted = pending_size;
      default: size_shifted = '0;
    endcase
  end

  assign pay_write = accept && !halted && command == ymr_pkg::CMD_BYTE &&
                     byte_position >= 8'd3 && byte_position < 8'(3 + ymr_pkg::PAYLOAD_BYTES) &&
                     hdr_data;
  assign ram_we = busy || pay_write;
  assign ram_waddr = busy ? clr_cnt[ABITS-1:0] : {slot_count, off[OB-1:0]};
  assign ram_wdata = busy ? 8'h00 : data_byte;
  assign ram_re = accept && command == ymr_pkg::CMD_READ;
  assign ram_raddr = ra_wide[ABITS-1:0];

  always_comb begin
    phase_next = phase;
    halted_next = halted;
    expected_block_next = expected_block;
    slot_count_next = slot_count;
    flush_block_index_next = flush_block_index;
    byte_position_next = byte_position;
    frame_type_next = frame_type;
    block_number_next = block_number;
    block_complement_next = block_complement;
    running_crc_next = running_crc;
    received_crc_next = received_crc;
    zero_seen_next = zero_seen;
    size_bytes_taken_next = size_bytes_taken;
    pending_size_next = pending_size;
    size_held_next = size_held;
    desc = '0;
    desc.flush_addr = flush_addr;
    desc_valid = 1'b0;

    if (command == ymr_pkg::CMD_READ) begin
      desc.count = 3'd1;
      desc.beats[0] = ymr_pkg::BT_READ;
      desc.zero_read = !(ra_wide < 32'(BUFFER_BYTES));
    end else if (!halted && command == ymr_pkg::CMD_BYTE) begin
      if (byte_position == 8'd0) frame_type_next = data_byte;
      else if (byte_position == 8'd1) block_number_next = data_byte;
      else if (byte_position == 8'd2) block_complement_next = data_byte;
      else if (byte_position < 8'(3 + ymr_pkg::PAYLOAD_BYTES))
        running_crc_next = ymr_pkg::crc_byte(running_crc, data_byte);
      else if (byte_position < 8'(ymr_pkg::FRAME_BYTES))
        received_crc_next = {received_crc[7:0], data_byte};
      if (zero_seen && size_bytes_taken < 3'd4) begin
        pending_size_next = {pending_size[23:0], data_byte};
        size_bytes_taken_next = size_bytes_taken + 3'd1;
      end else if (!zero_seen && byte_position >= 8'd3 &&
                   byte_position < 8'(ymr_pkg::FRAME_BYTES) && data_byte == 8'h00) begin
        zero_seen_next = 1'b1;
      end
      if (byte_position != 8'hFF) byte_position_next = byte_position + 8'd1;
    end else if (!halted && command == ymr_pkg::CMD_END) begin
      if (byte_position != 8'd0 && frame_type == ymr_pkg::SOH_BYTE &&
          byte_position >= 8'(ymr_pkg::FRAME_BYTES)) begin
        if (running_crc != received_crc) begin
          halted_next = 1'b1;
          desc.count = 3'd1;
          desc.beats[0] = ymr_pkg::BT_ERRCRC;
        end else if (phase == ymr_pkg::PH_START && null_block) begin
          if (size_shifted >= 32'(size_limit)) begin
            halted_next = 1'b1;
            desc.count = 3'd1;
            desc.beats[0] = ymr_pkg::BT_ERRSIZE;
          end else begin
            size_held_next = size_shifted;
            phase_next = ymr_pkg::PH_DATA;
            expected_block_next = 8'd1;
            slot_count_next = '0;
            flush_block_index_next = 8'd0;
            desc.count = 3'd4;
            desc.beats = {ymr_pkg::BT_C, ymr_pkg::BT_ACK, ymr_pkg::BT_ERASE1,
                          ymr_pkg::BT_ERASE0};
          end
        end else if (phase == ymr_pkg::PH_END && null_block) begin
          desc.size = size_held;
          desc.beats[0] = ymr_pkg::BT_DONE;
          desc.beats[1] = ymr_pkg::BT_ACK;
          desc.count = 3'd2;
          if (slot_count != '0) begin
            slot_count_next = '0;
            flush_block_index_next = flush_block_index + 8'd1;
            desc.beats[2] = ymr_pkg::BT_FLUSH;
            desc.count = 3'd3;
          end
          phase_next = ymr_pkg::PH_START;
        end else if (hdr_data) begin
          expected_block_next = expected_block + 8'd1;
          if (slot_inc >= (SW+1)'(SLOTS)) begin
            slot_count_next = '0;
            flush_block_index_next = flush_block_index + 8'd1;
            desc.beats[0] = ymr_pkg::BT_FLUSH;
            desc.beats[1] = ymr_pkg::BT_ACK;
            desc.count = 3'd2;
          end else begin
            slot_count_next = slot_inc[SW-1:0];
            desc.beats[0] = ymr_pkg::BT_ACK;
            desc.count = 3'd1;
          end
        end
      end else if (byte_position != 8'd0 && frame_type == ymr_pkg::EOT_BYTE) begin
        if (phase == ymr_pkg::PH_DATA) begin
          phase_next = ymr_pkg::PH_EOT2;
          desc.beats[0] = ymr_pkg::BT_NAK;
          desc.count = 3'd1;
        end else if (phase == ymr_pkg::PH_EOT2) begin
          phase_next = ymr_pkg::PH_END;
          desc.beats[0] = ymr_pkg::BT_ACK;
          desc.beats[1] = ymr_pkg::BT_C;
          desc.count = 3'd2;
        end
      end
      byte_position_next = 8'd0;
      frame_type_next = 8'd0;
      block_number_next = 8'd0;
      block_complement_next = 8'd0;
      running_crc_next = 16'd0;
      received_crc_next = 16'd0;
      zero_seen_next = 1'b0;
      size_bytes_taken_next = 3'd0;
      pending_size_next = 32'd0;
    end
    desc_valid = accept && desc.count != 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      size_limit <= ymr_pkg::SIZE_LIMIT_RESET;
      phase <= ymr_pkg::PH_START;
      halted <= 1'b0;
      expected_block <= '0;
      slot_count <= '0;
      flush_block_index <= '0;
      byte_position <= '0;
      frame_type <= '0;
      block_number <= '0;
      block_complement <= '0;
      running_crc <= '0;
      received_crc <= '0;
      zero_seen <= 1'b0;
      size_bytes_taken <= '0;
      pending_size <= '0;
      size_held <= '0;
    end else begin
      if (busy) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) size_limit <= cfg_wdata;
      if (accept) begin
        phase <= phase_next;
        halted <= halted_next;
        expected_block <= expected_block_next;
        slot_count <= slot_count_next;
        flush_block_index <= flush_block_index_next;
        byte_position <= byte_position_next;
        frame_type <= frame_type_next;
        block_number <= block_number_next;
        block_complement <= block_complement_next;
        running_crc <= running_crc_next;
        received_crc <= received_crc_next;
        zero_seen <= zero_seen_next;
        size_bytes_taken <= size_bytes_taken_next;
        pending_size <= pending_size_next;
        size_held <= size_held_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ymr_out.sv
`default_nettype none
module ymr_out (
  input wire logic clk,
  input wire logic rst,
  input wire logic desc_valid,
  input wire ymr_pkg::desc_t desc,
  input wire logic [7:0] rdata,
  output logic in_free,
  output logic out_valid,
  input wire logic out_ready,
  output logic [2:0] kind,
  output logic [7:0] value_byte,
  output logic [23:0] flash_address,
  output logic [31:0] transfer_size,
  output logic error_code,
  output logic last
);

  logic a_valid, b_valid;
  ymr_pkg::desc_t a_desc, b_desc;
  logic [7:0] b_data;
  logic [1:0] idx;
  logic b_done, a_move;
  logic [3:0] beat;

  assign last = 3'(idx) == b_desc.count - 3'd1;
  assign b_done = b_valid && out_ready && last;
  assign a_move = a_valid && (!b_valid || b_done);
  assign in_free = !a_valid || a_move;
  assign out_valid = b_valid;
  assign beat = b_desc.beats[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (in_free) a_valid <= desc_valid;
      if (a_move) begin
        b_valid <= 1'b1;
        idx <= '0;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end else if (b_valid && out_ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // read data from the buffer lands while the beat sits in the first stage
  always_ff @(posedge clk) begin
    if (in_free && desc_valid) a_desc <= desc;
    if (a_move) begin
      b_desc <= a_desc;
      b_data <= a_desc.zero_read ? 8'h00 : rdata;
    end
  end

  always_comb begin
    kind = ymr_pkg::KIND_REPLY;
    value_byte = 8'h00;
    flash_address = 24'h0;
    transfer_size = 32'h0;
    error_code = ymr_pkg::ERR_CRC;
    case (beat)
      ymr_pkg::BT_ERASE0: kind = ymr_pkg::KIND_ERASE;
      ymr_pkg::BT_ERASE1: begin
        kind = ymr_pkg::KIND_ERASE;
        flash_address = ymr_pkg::ERASE1_ADDR;
      end
      ymr_pkg::BT_ACK: value_byte = ymr_pkg::ACK_BYTE;
      ymr_pkg::BT_C: value_byte = ymr_pkg::C_BYTE;
      ymr_pkg::BT_NAK: value_byte = ymr_pkg::NAK_BYTE;
      ymr_pkg::BT_DONE: begin
        kind = ymr_pkg::KIND_DONE;
        transfer_size = b_desc.size;
      end
      ymr_pkg::BT_FLUSH: begin
        kind = ymr_pkg::KIND_FLUSH;
        flash_address = b_desc.flush_addr;
      end
      ymr_pkg::BT_ERRCRC: kind = ymr_pkg::KIND_ERROR;
      ymr_pkg::BT_ERRSIZE: begin
        kind = ymr_pkg::KIND_ERROR;
        error_code = ymr_pkg::ERR_SIZE;
      end
      ymr_pkg::BT_READ: begin
        kind = ymr_pkg::KIND_READ;
        value_byte = b_data;
      end
      default: kind = ymr_pkg::KIND_REPLY;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/ymr_checker.sv
`default_nettype none
module ymr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] kind,
  input wire logic [7:0] value_byte,
  input wire logic [23:0] flash_address,
  input wire logic error_code,
  input wire logic last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("output or input active after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value_byte) &&
    $stable(error_code) && $stable(last))
    else $error("stalled beat changed");

  a_read_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ymr_pkg::KIND_READ |-> last)
    else $error("read beat not last");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ymr_pkg::KIND_ERROR |-> last)
    else $error("error beat not last");

  // first erase always followed by the second one
  a_erase_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind == ymr_pkg::KIND_ERASE && flash_address == 24'h0
    |=> out_valid && kind == ymr_pkg::KIND_ERASE && flash_address == ymr_pkg::ERASE1_ADDR)
    else $error("erase pair broken");

endmodule

bind ymodem_crc_receiver ymr_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .value_byte(value_byte),
  .flash_address(flash_address), .error_code(error_code), .last(last)
);
`default_nettype wire
